>>> src/fkt_pkg.sv
package fkt_pkg;

  // Table geometry
  localparam int ENTRIES    = 128;
  localparam int CATEGORIES = 5;

  // Derived widths
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAT_SEL_W = (CATEGORIES > 1) ? $clog2(CATEGORIES) : 1;
  localparam int DEPTH     = CATEGORIES * ENTRIES;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // FNV-1a constants
  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_FOUND     = 2'd0,
    STAT_INSERTED  = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // Control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

>>> src/fnv1a_keyed_name_table_unit.sv
// Name bytes other than the last: one item per cycle while intake is open, no result.
// Last byte: the result follows a scan of the category's held hashes that ends at a hit,
// after all of them on a miss, or with no read if the category is empty or out of range;
// intake reopens as the result is presented; an earlier result still stalled holds it off.
// Reset (rst_n low, synchronous): running hash to the offset basis, all category
// counts to zero, no result pending; table contents are left as they are.
module fnv1a_keyed_name_table_unit
  import fkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_name_byte,
  input  logic        in_last_byte,
  input  logic        in_action,
  input  logic [2:0]  in_category,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_index,
  output logic [31:0] out_name_hash
);

  // State and datapath registers
  state_t              state_r, state_nxt;
  logic [31:0]         hash_r, hash_nxt;
  logic [31:0]         final_hash_r;
  logic                act_r;
  logic                cat_ok_r;
  logic [CAT_SEL_W-1:0] cat_sel_r;
  logic [ADDR_W-1:0]   base_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic                rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]    rd_idx_r;
  logic [31:0]         rdata_r;
  logic [CNT_W-1:0]    counts_r [CATEGORIES];
  status_t             res_status_r, res_status_nxt;
  logic [CNT_W-1:0]    res_index_r, res_index_nxt;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [6:0]          out_entry_index_r;
  logic [31:0]         out_name_hash_r;

  // Table memory
  logic [31:0]         mem [DEPTH];

  logic                in_fire;
  logic                out_load;
  logic [31:0]         folded;
  logic                in_cat_ok;
  logic [CAT_SEL_W-1:0] in_cat_sel;
  logic                hit;
  logic                scan_end;
  logic                insert_ok;
  logic                rd_en;
  logic                wr_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;

  // Fold one byte into the running hash
  assign folded     = (hash_r ^ {24'd0, in_name_byte}) * FNV_PRIME;
  assign in_cat_ok  = (32'(in_category) < CATEGORIES);
  assign in_cat_sel = CAT_SEL_W'(in_category);
  assign in_fire    = in_valid && !in_stall;

  // Scan compare and table access
  assign hit       = rd_pend_r && (rdata_r == final_hash_r);
  assign scan_end  = hit || (!rd_pend_r && (issue_r == cnt_r));
  assign insert_ok = !hit && act_r && cat_ok_r && (cnt_r < CNT_W'(ENTRIES));
  assign rd_en     = (state_r == S_SCAN) && !scan_end && (issue_r < cnt_r);
  assign wr_en     = (state_r == S_SCAN) && scan_end && insert_ok;
  assign rd_addr   = base_r + ADDR_W'(issue_r);
  assign wr_addr   = base_r + ADDR_W'(cnt_r);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire && in_last_byte) state_nxt = S_SCAN;
      S_SCAN: if (scan_end) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs and datapath next values
  always_comb begin
    in_stall       = (state_r != S_IDLE);
    hash_nxt       = hash_r;
    issue_nxt      = issue_r;
    rd_pend_nxt    = 1'b0;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    unique case (state_r)
      S_IDLE: begin
        issue_nxt = '0;
        if (in_fire) hash_nxt = in_last_byte ? FNV_BASIS : folded;
      end
      S_SCAN: begin
        if (rd_en) begin
          issue_nxt   = issue_r + CNT_W'(1);
          rd_pend_nxt = 1'b1;
        end
        if (scan_end) begin
          if (hit) begin
            res_status_nxt = STAT_FOUND;
            res_index_nxt  = rd_idx_r;
          end else if (!act_r) begin
            res_status_nxt = STAT_NOT_FOUND;
            res_index_nxt  = '0;
          end else if (insert_ok) begin
            res_status_nxt = STAT_INSERTED;
            res_index_nxt  = cnt_r;
          end else begin
            res_status_nxt = STAT_FULL;
            res_index_nxt  = '0;
          end
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= FNV_BASIS;
      rd_pend_r   <= 1'b0;
      issue_r     <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < CATEGORIES; c++) counts_r[c] <= '0;
    end else begin
      state_r   <= state_nxt;
      hash_r    <= hash_nxt;
      rd_pend_r <= rd_pend_nxt;
      issue_r   <= issue_nxt;
      if (wr_en) counts_r[cat_sel_r] <= cnt_r + CNT_W'(1);
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Capture the name at its last byte; register the read index and the result
  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      final_hash_r <= folded;
      act_r        <= in_action;
      cat_ok_r     <= in_cat_ok;
      cat_sel_r    <= in_cat_sel;
      base_r       <= ADDR_W'(ADDR_W'(in_cat_sel) * ADDR_W'(ENTRIES));
      cnt_r        <= in_cat_ok ? counts_r[in_cat_sel] : '0;
    end
    rd_idx_r     <= issue_r;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
  end

  // Table memory: at most one access per cycle, a write or a registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= final_hash_r;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r      <= res_status_r;
      out_entry_index_r <= 7'(res_index_r);
      out_name_hash_r   <= final_hash_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_entry_index_r;
  assign out_name_hash   = out_name_hash_r;

  // Checks
  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r == S_SCAN))
    else $error("table read completed outside a scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= CNT_W'(ENTRIES)))
    else $error("category count above table size");

  a_insert_bumps_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (counts_r[cat_sel_r] == $past(cnt_r) + CNT_W'(1)))
    else $error("insert did not advance the category count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised without a finished scan");

endmodule

>>> tb/sv/fnv1a_table_check.sv
`timescale 1ns / 1ps

module fnv1a_table_check
  import fkt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_name_byte,
  input  logic        in_last_byte,
  input  logic        in_action,
  input  logic [2:0]  in_category,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [6:0]  out_entry_index,
  input  logic [31:0] out_name_hash,
  output int          fail_count,
  output int          outstanding
);

  typedef struct {
    status_t     status;
    logic [6:0]  index;
    logic [31:0] hash;
  } lookup_result_t;

  // Results still owed by the block, oldest first
  lookup_result_t pending_lookups[$];

  // Shadow of the block's state
  logic [31:0] hash_acc;
  logic [31:0] stored_hash [CATEGORIES][ENTRIES];
  int          held [CATEGORIES];

  // One FNV-1a round: xor the byte in, multiply by the prime mod 2^32
  function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
    return (h ^ {24'd0, b}) * FNV_PRIME;
  endfunction

  // Search the category list and insert when the hash is absent, the action asks and there is room
  task automatic resolve_name(input logic [31:0] h, input logic act, input logic [2:0] cat,
                              output lookup_result_t r);
    bit hit;
    int slot;
    hit     = 1'b0;
    slot    = 0;
    r.hash  = h;
    r.index = '0;
    if (cat >= CATEGORIES) begin
      r.status = act ? STAT_FULL : STAT_NOT_FOUND;
    end else begin
      for (int i = 0; i < held[cat]; i++) begin
        if (!hit && stored_hash[cat][i] == h) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        r.status = STAT_FOUND;
        r.index  = slot[6:0];
      end else if (!act) begin
        r.status = STAT_NOT_FOUND;
      end else if (held[cat] >= ENTRIES) begin
        r.status = STAT_FULL;
      end else begin
        stored_hash[cat][held[cat]] = h;
        r.index  = 7'(held[cat]);
        r.status = STAT_INSERTED;
        held[cat]++;
      end
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    logic [31:0]    folded;
    bit             bad;
    if (!rst_n) begin
      hash_acc   = FNV_BASIS;
      fail_count = 0;
      pending_lookups.delete();
      for (int c = 0; c < CATEGORIES; c++) held[c] = 0;
    end else begin
      // Compare each result item with the oldest prediction
      if (out_valid && !out_stall) begin
        if (pending_lookups.size() == 0) begin
          $display("%0t: unexpected result status %0d index %0d hash %08h", $time,
                   out_status, out_entry_index, out_name_hash);
          fail_count++;
        end else begin
          want = pending_lookups.pop_front();
          bad  = 1'b0;
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
            bad = 1'b1;
          end
          if (out_entry_index !== want.index) begin
            $display("%0t: entry_index expected %0d, got %0d", $time, want.index,
                     out_entry_index);
            bad = 1'b1;
          end
          if (out_name_hash !== want.hash) begin
            $display("%0t: name_hash expected %08h, got %08h", $time, want.hash,
                     out_name_hash);
            bad = 1'b1;
          end
          if (bad) fail_count++;
        end
      end
      // Fold each accepted byte; resolve the name on its last byte
      if (in_valid && !in_stall) begin
        folded = fnv_fold(hash_acc, in_name_byte);
        if (in_last_byte) begin
          hash_acc = FNV_BASIS;
          resolve_name(folded, in_action, in_category, want);
          pending_lookups.push_back(want);
        end else begin
          hash_acc = folded;
        end
      end
    end
    outstanding <= pending_lookups.size();
  end

endmodule

>>> tb/sv/tb_fnv1a_keyed_name_table_unit.sv
`timescale 1ns / 1ps

module tb_fnv1a_keyed_name_table_unit
  import fkt_pkg::*;
();

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 4000;
  localparam int POOL_SIZE    = 40;
  localparam int MAX_NAME     = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_name_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        in_action = 1'b0;
  logic [2:0]  in_category = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [6:0]  out_entry_index;
  logic [31:0] out_name_hash;

  int fail_count;
  int outstanding;
  int idle_cycles = 0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  logic [7:0] name_buf [MAX_NAME];
  int         name_len;
  logic [7:0] pool_bytes [POOL_SIZE][MAX_NAME];
  int         pool_len [POOL_SIZE];

  fnv1a_keyed_name_table_unit DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_byte   (in_name_byte),
    .in_last_byte   (in_last_byte),
    .in_action      (in_action),
    .in_category    (in_category),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_entry_index(out_entry_index),
    .out_name_hash  (out_name_hash)
  );

  fnv1a_table_check table_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_name_byte   (in_name_byte),
    .in_last_byte   (in_last_byte),
    .in_action      (in_action),
    .in_category    (in_category),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_entry_index(out_entry_index),
    .out_name_hash  (out_name_hash),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result side in phases: none, light, heavy, periodic
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 8 < 3);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte item; open a new burst after a random gap when due
  task automatic send_item(input logic [7:0] b, input logic last, input logic act,
                           input logic [2:0] cat);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_name_byte <= b;
    in_last_byte <= last;
    in_action    <= act;
    in_category  <= cat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  // Send the name in name_buf; only the last byte's action and category count
  task automatic send_name(input logic act, input logic [2:0] cat);
    for (int k = 0; k < name_len; k++) begin
      if (k == name_len - 1) begin
        send_item(name_buf[k], 1'b1, act, cat);
      end else begin
        send_item(name_buf[k], 1'b0, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic load_name(input int len, input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2);
    name_len    = len;
    name_buf[0] = b0;
    name_buf[1] = b1;
    name_buf[2] = b2;
  endtask

  // Hold off the sender until every result has arrived
  task automatic drain_results();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int fill_point;
    int random_end;
    int pick;
    int stride;
    int start;
    logic [2:0] fill_cat;
    bit filled;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty lookup, insert, duplicate insert, extreme bytes
    load_name(1, 8'h00, 8'h00, 8'h00);
    send_name(1'b0, 3'd0);
    send_name(1'b1, 3'd0);
    send_name(1'b1, 3'd0);
    load_name(1, 8'hff, 8'h00, 8'h00);
    send_name(1'b1, 3'd0);
    send_name(1'b0, 3'd0);
    // Multi-byte names and lists kept apart per category
    load_name(3, 8'h61, 8'h62, 8'h63);
    send_name(1'b1, 3'd1);
    send_name(1'b0, 3'd1);
    load_name(2, 8'hff, 8'h00, 8'h00);
    send_name(1'b1, 3'd2);
    load_name(1, 8'h00, 8'h00, 8'h00);
    send_name(1'b0, 3'd2);
    load_name(1, 8'h80, 8'h00, 8'h00);
    send_name(1'b1, 3'd3);
    load_name(1, 8'h7f, 8'h00, 8'h00);
    send_name(1'b1, 3'd4);
    send_name(1'b0, 3'd4);
    // Categories past the last table
    load_name(1, 8'h00, 8'h00, 8'h00);
    send_name(1'b0, 3'd5);
    send_name(1'b1, 3'd6);
    send_name(1'b1, 3'd7);
    send_name(1'b0, 3'd7);
    drain_results();

    // Build a pool of names so lookups and re-inserts hit often
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_len[p] = $urandom_range(1, 6);
      for (int k = 0; k < MAX_NAME; k++) pool_bytes[p][k] = 8'($urandom_range(0, 255));
    end

    fill_point = items_sent + $urandom_range(300, 900);
    random_end = items_sent + RANDOM_ITEMS;
    filled     = 1'b0;
    while (items_sent < random_end) begin
      // Fill one category past its capacity with distinct one-byte names
      if (!filled && items_sent >= fill_point) begin
        filled   = 1'b1;
        fill_cat = 3'($urandom_range(0, CATEGORIES - 1));
        stride   = 2 * $urandom_range(0, 127) + 1;
        start    = $urandom_range(0, 255);
        name_len = 1;
        for (int k = 0; k < 200; k++) begin
          name_buf[0] = 8'(start + k * stride);
          send_name(1'b1, fill_cat);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        pick     = $urandom_range(0, POOL_SIZE - 1);
        name_len = pool_len[pick];
        for (int k = 0; k < name_len; k++) name_buf[k] = pool_bytes[pick][k];
      end else begin
        pick     = $urandom_range(0, 99);
        name_len = (pick < 70) ? $urandom_range(1, 3) :
                   (pick < 95) ? $urandom_range(4, 8) : $urandom_range(9, MAX_NAME);
        for (int k = 0; k < name_len; k++) name_buf[k] = 8'($urandom_range(0, 255));
      end
      send_name(1'($urandom_range(0, 1)),
                ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, CATEGORIES - 1))
                                             : 3'($urandom_range(CATEGORIES, 7)));
      if ($urandom_range(0, 39) == 0) drain_results();
    end

    // Wait out the last results and any trailing scan
    drain_results();
    repeat (ENTRIES + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
